/* rtl/fbd_pkg.sv */
// ----------------------------------------------------------------------------
// fbd_pkg
// Shared types and constants of the frame box downscaler: field widths,
// register indexes, scale modes, controller states and the command and
// status groups between controller and datapath.
// ----------------------------------------------------------------------------
package fbd_pkg;

    localparam int PIX_W      = 16;
    localparam int COL_W      = 10;
    localparam int ROW_W      = 9;
    localparam int MODE_W     = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 10;

    localparam int DEF_SOURCE_WIDTH = 640;
    localparam int DEF_SOURCE_ROWS  = 480;
    localparam int DEF_ACTIVE_ROWS  = 400;
    localparam int DEF_MAX_SPAN     = 4;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE_MODE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEST_WIDTH  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DEST_HEIGHT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CLIP_WIDTH  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CLIP_HEIGHT = 3'd4;

    // scale modes
    localparam logic [MODE_W-1:0] MODE_MAX  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_AVG  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_MID  = 2'd2;
    localparam logic [MODE_W-1:0] MODE_PASS = 2'd3;

    localparam logic [MODE_W-1:0] RST_SCALE_MODE  = MODE_AVG;
    localparam logic [COL_W-1:0]  RST_DEST_WIDTH  = 10'd320;
    localparam logic [ROW_W-1:0]  RST_DEST_HEIGHT = 9'd200;
    localparam logic [COL_W-1:0]  RST_CLIP_WIDTH  = 10'd320;
    localparam logic [ROW_W-1:0]  RST_CLIP_HEIGHT = 9'd240;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RST_DIV,
        S_RST_WAIT,
        S_EVAL,
        S_ACC,
        S_DIV,
        S_ADV,
        S_PUSH
    } t_state;

    typedef struct packed {
        logic in_ready;
        logic rst_start;
        logic rst_apply;
        logic eval;
        logic acc;
        logic adv;
        logic push;
    } t_cmd;

    typedef struct packed {
        logic in_valid;
        logic in_fs;
        logic div_busy;
        logic emit;
        logic out_free;
    } t_sts;

endpackage

/* rtl/frame_box_downscaler.sv */
// Sequence: an accepted beat passes through the evaluate, accumulate, divide,
//   advance and, for a result, push states; a beat with frame_start set first
//   restarts the bound dividers. A new source beat is taken only once the last
//   is done, after the bit-serial dividers that place the next column span and row band.
// Reset: synchronous, active low; counters, registers and handshakes clear,
//   the column line store keeps its contents and is rewritten on each block.
// ----------------------------------------------------------------------------
// frame_box_downscaler
// Box-filter downscaler for RGB565 frames: max, average or midpoint of each
// source block, or pass-through inside a clip window.
// ----------------------------------------------------------------------------
module frame_box_downscaler #(
    parameter int SOURCE_WIDTH = fbd_pkg::DEF_SOURCE_WIDTH,
    parameter int SOURCE_ROWS  = fbd_pkg::DEF_SOURCE_ROWS,
    parameter int ACTIVE_ROWS  = fbd_pkg::DEF_ACTIVE_ROWS,
    parameter int MAX_SPAN     = fbd_pkg::DEF_MAX_SPAN
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // source beats
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [fbd_pkg::PIX_W-1:0]      i_src_pixel,
    input  logic                           i_frame_start,
    // destination beats
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [fbd_pkg::PIX_W-1:0]      o_out_pixel,
    output logic [fbd_pkg::COL_W-1:0]      o_out_col,
    output logic [fbd_pkg::ROW_W-1:0]      o_out_row,
    output logic                           o_frame_done,
    // configuration writes
    input  logic                           i_cfg_we,
    input  logic [fbd_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [fbd_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import fbd_pkg::*;

    t_cmd cmd;
    t_sts sts;

    // The controller walks one beat through restart, evaluate, accumulate,
    // divide, advance and push; the datapath owns all storage and arithmetic.
    fbd_controller u_ctrl (
        .i_clk,
        .i_rst_n,
        .i_sts (sts),
        .o_cmd (cmd)
    );

    fbd_datapath #(
        .SOURCE_WIDTH (SOURCE_WIDTH),
        .SOURCE_ROWS  (SOURCE_ROWS),
        .ACTIVE_ROWS  (ACTIVE_ROWS),
        .MAX_SPAN     (MAX_SPAN)
    ) u_dp (
        .i_clk,
        .i_rst_n,
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_in_valid,
        .i_src_pixel,
        .i_frame_start,
        .i_cfg_we,
        .i_cfg_idx,
        .i_cfg_data,
        .o_out_valid,
        .i_out_stall,
        .o_out_pixel,
        .o_out_col,
        .o_out_row,
        .o_frame_done
    );

    // hold the source side while a beat is in flight
    assign o_in_stall = !cmd.in_ready;
endmodule

/* rtl/fbd_divider.sv */
// ----------------------------------------------------------------------------
// fbd_divider
// Restoring divider, one quotient bit per cycle. The quotient must fit in
// QUO_W bits; busy stays high until every quotient bit is produced.
// ----------------------------------------------------------------------------
module fbd_divider #(
    parameter int NUM_W = 16,
    parameter int DEN_W = 8,
    parameter int QUO_W = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic [QUO_W-1:0] o_quo,
    output logic             o_busy
);
    localparam int XW  = (NUM_W > DEN_W + QUO_W) ? NUM_W : DEN_W + QUO_W;
    localparam int CNW = $clog2(QUO_W + 1);

    logic [XW-1:0]    r_rem, r_dsh;
    logic [QUO_W-1:0] r_quo;
    logic [CNW-1:0]   r_cnt;
    logic             r_busy;
    logic             ge;

    assign ge = (r_rem >= r_dsh);

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= XW'(i_num);
            r_dsh <= XW'(i_den) << (QUO_W - 1);
            r_quo <= '0;
        end else if (r_busy) begin
            if (ge) begin
                r_rem <= r_rem - r_dsh;
            end
            r_dsh <= r_dsh >> 1;
            r_quo <= (r_quo << 1) | QUO_W'(ge);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNW'(QUO_W);
        end else if (r_busy) begin
            r_cnt  <= r_cnt - CNW'(1);
            r_busy <= (r_cnt != CNW'(1));
        end
    end

    assign o_quo  = r_quo;
    assign o_busy = r_busy;
endmodule

/* rtl/fbd_controller.sv */
// ----------------------------------------------------------------------------
// fbd_controller
// Sequencer for one source pixel: optional frame restart, evaluate,
// accumulate, divide, advance counters and hand the result to the output.
// ----------------------------------------------------------------------------
module fbd_controller (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  fbd_pkg::t_sts i_sts,
    output fbd_pkg::t_cmd o_cmd
);
    import fbd_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_sts.in_valid) begin
                    n_state = i_sts.in_fs ? S_RST_DIV : S_EVAL;
                end
            end
            S_RST_DIV:  n_state = S_RST_WAIT;
            S_RST_WAIT: begin
                if (!i_sts.div_busy) begin
                    n_state = S_EVAL;
                end
            end
            S_EVAL: n_state = S_ACC;
            S_ACC:  n_state = S_DIV;
            S_DIV: begin
                if (!i_sts.div_busy) begin
                    n_state = S_ADV;
                end
            end
            S_ADV: n_state = i_sts.emit ? S_PUSH : S_IDLE;
            S_PUSH: begin
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        case (r_state)
            S_IDLE:     o_cmd.in_ready  = 1'b1;
            S_RST_DIV:  o_cmd.rst_start = 1'b1;
            S_RST_WAIT: o_cmd.rst_apply = !i_sts.div_busy;
            S_EVAL:     o_cmd.eval      = 1'b1;
            S_ACC:      o_cmd.acc       = 1'b1;
            S_ADV:      o_cmd.adv       = 1'b1;
            S_PUSH:     o_cmd.push      = i_sts.out_free;
            default:    o_cmd = '0;
        endcase
    end
endmodule

/* rtl/fbd_datapath.sv */
// ----------------------------------------------------------------------------
// fbd_datapath
// Position counters, span bounds, line store of per-column partials,
// dividers for bounds and averages, and the output register.
// ----------------------------------------------------------------------------
module fbd_datapath #(
    parameter int SOURCE_WIDTH = 640,
    parameter int SOURCE_ROWS  = 480,
    parameter int ACTIVE_ROWS  = 400,
    parameter int MAX_SPAN     = 4
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  fbd_pkg::t_cmd                    i_cmd,
    output fbd_pkg::t_sts                    o_sts,
    input  logic                             i_in_valid,
    input  logic [fbd_pkg::PIX_W-1:0]        i_src_pixel,
    input  logic                             i_frame_start,
    input  logic                             i_cfg_we,
    input  logic [fbd_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [fbd_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic [fbd_pkg::PIX_W-1:0]        o_out_pixel,
    output logic [fbd_pkg::COL_W-1:0]        o_out_col,
    output logic [fbd_pkg::ROW_W-1:0]        o_out_row,
    output logic                             o_frame_done
);
    import fbd_pkg::*;

    localparam int UR     = (ACTIVE_ROWS < SOURCE_ROWS) ? ACTIVE_ROWS : SOURCE_ROWS;
    localparam int CW     = $clog2(SOURCE_WIDTH + 1);
    localparam int RW     = $clog2(SOURCE_ROWS + 1);
    localparam int AW     = $clog2(SOURCE_WIDTH);
    localparam int MIN_DW = (SOURCE_WIDTH + MAX_SPAN - 1) / MAX_SPAN;
    localparam int MIN_DH = (UR + MAX_SPAN - 1) / MAX_SPAN;
    localparam int NCW    = $clog2((SOURCE_WIDTH + 1) * SOURCE_WIDTH + 1);
    localparam int NRW    = $clog2((UR + 1) * UR + 1);
    localparam int CNT_W  = $clog2(SOURCE_WIDTH * UR + 1);
    localparam int S5_W   = CNT_W + 5;
    localparam int S6_W   = CNT_W + 6;
    localparam int ENT_W  = 2 * S5_W + S6_W + 2 * PIX_W;

    // configuration
    logic [MODE_W-1:0] r_mode;
    logic [COL_W-1:0]  r_dest_w, r_clip_w;
    logic [ROW_W-1:0]  r_dest_h, r_clip_h;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= RST_SCALE_MODE;
            r_dest_w <= RST_DEST_WIDTH;
            r_dest_h <= RST_DEST_HEIGHT;
            r_clip_w <= RST_CLIP_WIDTH;
            r_clip_h <= RST_CLIP_HEIGHT;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SCALE_MODE:  r_mode   <= i_cfg_data[MODE_W-1:0];
                CFG_DEST_WIDTH:  r_dest_w <= i_cfg_data[COL_W-1:0];
                CFG_DEST_HEIGHT: r_dest_h <= i_cfg_data[ROW_W-1:0];
                CFG_CLIP_WIDTH:  r_clip_w <= i_cfg_data[COL_W-1:0];
                CFG_CLIP_HEIGHT: r_clip_h <= i_cfg_data[ROW_W-1:0];
                default: ;
            endcase
        end
    end

    logic [CW-1:0] dw_eff, cw_eff;
    logic [RW-1:0] dh_eff, ch_eff;

    always_comb begin
        if (r_dest_w < MIN_DW)            dw_eff = CW'(MIN_DW);
        else if (r_dest_w > SOURCE_WIDTH) dw_eff = CW'(SOURCE_WIDTH);
        else                              dw_eff = CW'(r_dest_w);
        if (r_dest_h < MIN_DH)            dh_eff = RW'(MIN_DH);
        else if (r_dest_h > UR)           dh_eff = RW'(UR);
        else                              dh_eff = RW'(r_dest_h);
        cw_eff = (r_clip_w < SOURCE_WIDTH) ? CW'(r_clip_w) : CW'(SOURCE_WIDTH);
        ch_eff = (r_clip_h < SOURCE_ROWS)  ? RW'(r_clip_h) : RW'(SOURCE_ROWS);
    end

    // input capture
    logic [PIX_W-1:0] r_pix;
    logic             accept;

    assign accept = i_cmd.in_ready & i_in_valid;

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_pix <= i_src_pixel;
        end
    end

    // position state
    logic [CW-1:0] r_sc, r_dci, r_span_lo, r_span_hi;
    logic [RW-1:0] r_sr, r_dri, r_band_lo, r_band_hi;

    // dividers for span and band bounds
    logic [NCW-1:0] r_col_num, col_num;
    logic [NRW-1:0] r_row_num, row_num;
    logic [CW-1:0]  col_quo;
    logic [RW-1:0]  row_quo;
    logic           col_busy, row_busy, bnd_start;

    assign bnd_start = i_cmd.rst_start | i_cmd.acc;
    assign col_num   = i_cmd.rst_start ? NCW'(SOURCE_WIDTH) : r_col_num;
    assign row_num   = i_cmd.rst_start ? NRW'(UR) : r_row_num;

    fbd_divider #(.NUM_W(NCW), .DEN_W(CW), .QUO_W(CW)) u_col_div (
        .i_clk, .i_rst_n, .i_start(bnd_start), .i_num(col_num), .i_den(dw_eff),
        .o_quo(col_quo), .o_busy(col_busy)
    );

    fbd_divider #(.NUM_W(NRW), .DEN_W(RW), .QUO_W(RW)) u_row_div (
        .i_clk, .i_rst_n, .i_start(bnd_start), .i_num(row_num), .i_den(dh_eff),
        .o_quo(row_quo), .o_busy(row_busy)
    );

    // evaluation of the current pixel
    logic [CW:0]   sc1;
    logic [RW:0]   sr1;
    logic          active, row_end, frame_wrap, col_adv, row_adv;
    logic          emit_scale, pass;
    logic [NCW-1:0] col_idx2;
    logic [NRW-1:0] row_idx2;

    always_comb begin
        sc1        = {1'b0, r_sc} + 1'b1;
        sr1        = {1'b0, r_sr} + 1'b1;
        active     = (r_sr < UR) && (r_dri < dh_eff) && (r_dci < dw_eff);
        emit_scale = active && (r_mode != MODE_PASS) && (sc1 == r_span_hi)
                     && (sr1 == r_band_hi);
        pass       = (r_mode == MODE_PASS) && (r_sc < cw_eff) && (r_sr < ch_eff);
        row_end    = (sc1 >= SOURCE_WIDTH);
        frame_wrap = row_end && (sr1 >= SOURCE_ROWS);
        col_adv    = (r_dci < dw_eff) && (sc1 >= r_span_hi);
        row_adv    = row_end && (r_sr < UR) && (r_dri < dh_eff) && (sr1 >= r_band_hi);
        col_idx2   = NCW'(r_dci) + NCW'(2);
        row_idx2   = NRW'(r_dri) + NRW'(2);
    end

    logic                r_active, r_first, r_emit, r_pass;
    logic [CNT_W-1:0]    r_cnt;
    logic [COL_W-1:0]    r_res_col;
    logic [ROW_W-1:0]    r_res_row;
    logic                r_res_fd;
    logic                r_col_rst, r_col_shift, r_col_bump;
    logic                r_row_rst, r_row_shift, r_row_bump;
    logic [CW-1:0]       r_next_sc;
    logic [RW-1:0]       r_next_sr;

    always_ff @(posedge i_clk) begin
        if (i_cmd.eval) begin
            r_active  <= active;
            r_first   <= (r_sr == r_band_lo) && (r_sc == r_span_lo);
            r_pass    <= pass;
            r_cnt     <= CNT_W'(CNT_W'(r_span_hi - r_span_lo) * CNT_W'(r_band_hi - r_band_lo));
            if (pass) begin
                r_res_col <= COL_W'(r_sc);
                r_res_row <= ROW_W'(r_sr);
                r_res_fd  <= (sc1 == cw_eff) && (sr1 == ch_eff);
            end else begin
                r_res_col <= COL_W'(r_dci);
                r_res_row <= ROW_W'(r_dri);
                r_res_fd  <= ({1'b0, r_dci} + 1'b1 == dw_eff)
                             && ({1'b0, r_dri} + 1'b1 == dh_eff);
            end
            // column plan: a new row restarts the span tracker
            r_col_rst   <= row_end;
            r_col_shift <= !row_end && col_adv && ({1'b0, r_dci} + 1'b1 < dw_eff);
            r_col_bump  <= !row_end && col_adv;
            r_col_num   <= row_end ? NCW'(SOURCE_WIDTH)
                                   : NCW'(col_idx2 * NCW'(SOURCE_WIDTH));
            // row plan: a wrapped frame restarts the band tracker
            r_row_rst   <= frame_wrap;
            r_row_shift <= !frame_wrap && row_adv && ({1'b0, r_dri} + 1'b1 < dh_eff);
            r_row_bump  <= !frame_wrap && row_adv;
            r_row_num   <= frame_wrap ? NRW'(UR) : NRW'(row_idx2 * NRW'(UR));
            r_next_sc   <= row_end ? '0 : CW'(sc1);
            r_next_sr   <= row_end ? (frame_wrap ? '0 : RW'(sr1)) : r_sr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_emit <= 1'b0;
        end else if (i_cmd.eval) begin
            r_emit <= emit_scale | pass;
        end
    end

    // counter update: restart on frame start, advance after the divide
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sc      <= '0;
            r_sr      <= '0;
            r_dci     <= '0;
            r_dri     <= '0;
            r_span_lo <= '0;
            r_span_hi <= '0;
            r_band_lo <= '0;
            r_band_hi <= '0;
        end else if (i_cmd.rst_apply) begin
            r_sc      <= '0;
            r_sr      <= '0;
            r_dci     <= '0;
            r_dri     <= '0;
            r_span_lo <= '0;
            r_span_hi <= col_quo;
            r_band_lo <= '0;
            r_band_hi <= row_quo;
        end else if (i_cmd.adv) begin
            r_sc <= r_next_sc;
            r_sr <= r_next_sr;
            if (r_col_rst) begin
                r_dci     <= '0;
                r_span_lo <= '0;
                r_span_hi <= col_quo;
            end else if (r_col_bump) begin
                r_dci <= r_dci + 1'b1;
                if (r_col_shift) begin
                    r_span_lo <= r_span_hi;
                    r_span_hi <= (col_quo <= r_span_hi) ? r_span_hi + 1'b1 : col_quo;
                end
            end
            if (r_row_rst) begin
                r_dri     <= '0;
                r_band_lo <= '0;
                r_band_hi <= row_quo;
            end else if (r_row_bump) begin
                r_dri <= r_dri + 1'b1;
                if (r_row_shift) begin
                    r_band_lo <= r_band_hi;
                    r_band_hi <= (row_quo <= r_band_hi) ? r_band_hi + 1'b1 : row_quo;
                end
            end
        end
    end

    // line store of column partials {rsum, gsum, bsum, lo, hi}
    logic [ENT_W-1:0] mem [SOURCE_WIDTH];
    logic [ENT_W-1:0] r_rd, wr_ent;
    logic [AW-1:0]    addr;

    assign addr = r_dci[AW-1:0];

    always_ff @(posedge i_clk) begin
        r_rd <= mem[addr];
        if (i_cmd.acc && r_active) begin
            mem[addr] <= wr_ent;
        end
    end

    logic [S5_W-1:0]  old_r, old_b, new_r, new_b;
    logic [S6_W-1:0]  old_g, new_g;
    logic [PIX_W-1:0] old_lo, old_hi, new_lo, new_hi;

    always_comb begin
        {old_r, old_g, old_b, old_lo, old_hi} = r_rd;
        if (r_first) begin
            new_r  = S5_W'(r_pix[15:11]);
            new_g  = S6_W'(r_pix[10:5]);
            new_b  = S5_W'(r_pix[4:0]);
            new_lo = r_pix;
            new_hi = r_pix;
        end else begin
            new_r  = old_r + S5_W'(r_pix[15:11]);
            new_g  = old_g + S6_W'(r_pix[10:5]);
            new_b  = old_b + S5_W'(r_pix[4:0]);
            new_lo = (r_pix < old_lo) ? r_pix : old_lo;
            new_hi = (r_pix > old_hi) ? r_pix : old_hi;
        end
        wr_ent = {new_r, new_g, new_b, new_lo, new_hi};
    end

    // average dividers; a quotient past the channel top saturates
    logic [PIX_W-1:0] r_lo, r_hi;
    logic             r_sat_r, r_sat_g, r_sat_b;
    logic [4:0]       q_r, q_b;
    logic [5:0]       q_g;
    logic             br, bg, bb;

    always_ff @(posedge i_clk) begin
        if (i_cmd.acc) begin
            r_lo    <= new_lo;
            r_hi    <= new_hi;
            r_sat_r <= new_r >= {r_cnt, 5'd0};
            r_sat_g <= new_g >= {r_cnt, 6'd0};
            r_sat_b <= new_b >= {r_cnt, 5'd0};
        end
    end

    fbd_divider #(.NUM_W(S5_W), .DEN_W(CNT_W), .QUO_W(5)) u_r_div (
        .i_clk, .i_rst_n, .i_start(i_cmd.acc), .i_num(new_r), .i_den(r_cnt),
        .o_quo(q_r), .o_busy(br)
    );
    fbd_divider #(.NUM_W(S6_W), .DEN_W(CNT_W), .QUO_W(6)) u_g_div (
        .i_clk, .i_rst_n, .i_start(i_cmd.acc), .i_num(new_g), .i_den(r_cnt),
        .o_quo(q_g), .o_busy(bg)
    );
    fbd_divider #(.NUM_W(S5_W), .DEN_W(CNT_W), .QUO_W(5)) u_b_div (
        .i_clk, .i_rst_n, .i_start(i_cmd.acc), .i_num(new_b), .i_den(r_cnt),
        .o_quo(q_b), .o_busy(bb)
    );

    // result value
    logic [PIX_W-1:0] res_pix, r_res_pix;
    logic [5:0]       mid_r, mid_b;
    logic [6:0]       mid_g;

    always_comb begin
        mid_r = ({1'b0, r_lo[15:11]} + {1'b0, r_hi[15:11]}) >> 1;
        mid_g = ({1'b0, r_lo[10:5]} + {1'b0, r_hi[10:5]}) >> 1;
        mid_b = ({1'b0, r_lo[4:0]} + {1'b0, r_hi[4:0]}) >> 1;
        case (r_mode)
            MODE_MAX: res_pix = r_hi;
            MODE_AVG: res_pix = {r_sat_r ? 5'd31 : q_r, r_sat_g ? 6'd63 : q_g,
                                 r_sat_b ? 5'd31 : q_b};
            MODE_MID: res_pix = {mid_r[4:0], mid_g[5:0], mid_b[4:0]};
            default:  res_pix = r_pix;
        endcase
        if (r_pass) begin
            res_pix = r_pix;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.adv) begin
            r_res_pix <= res_pix;
        end
    end

    // output register
    logic r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.push) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            o_out_pixel  <= r_res_pix;
            o_out_col    <= r_res_col;
            o_out_row    <= r_res_row;
            o_frame_done <= r_res_fd;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_sts.in_valid = i_in_valid;
    assign o_sts.in_fs    = i_frame_start;
    assign o_sts.div_busy = col_busy | row_busy | br | bg | bb;
    assign o_sts.emit     = r_emit;
    assign o_sts.out_free = !r_out_valid || !i_out_stall;
endmodule

/* tb/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for frame_box_downscaler. A directed table walks the
// register extremes, every scale mode, clip saturation and a zero clip. Random
// frames follow: a full row of single-pixel blocks, an average over a block
// whose span narrows mid-band so that the channel quotients saturate, clipped
// pass-through, and mixed settings with stray frame starts. A behavioral
// downscaler predicts every destination beat, and a scoreboard compares them.
// ----------------------------------------------------------------------------
module tb_top;
    import fbd_pkg::*;

    localparam int SRC_W    = DEF_SOURCE_WIDTH;
    localparam int SRC_R    = DEF_SOURCE_ROWS;
    localparam int USED_R   = DEF_ACTIVE_ROWS < DEF_SOURCE_ROWS ? DEF_ACTIVE_ROWS : DEF_SOURCE_ROWS;
    localparam int SPAN     = DEF_MAX_SPAN;
    localparam int SETTLE   = 64;     // cycles after the last result before a write
    localparam int HANG_MAX = 4000;   // cycles with no beat moving either way

    // ------------------------------------------------------------------
    // DUT ports
    // ------------------------------------------------------------------
    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_stall;
    logic [PIX_W-1:0]      i_src_pixel = '0;
    logic                  i_frame_start = 1'b0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    logic [PIX_W-1:0]      o_out_pixel;
    logic [COL_W-1:0]      o_out_col;
    logic [ROW_W-1:0]      o_out_row;
    logic                  o_frame_done;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    frame_box_downscaler DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_src_pixel  (i_src_pixel),
        .i_frame_start(i_frame_start),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_out_pixel  (o_out_pixel),
        .o_out_col    (o_out_col),
        .o_out_row    (o_out_row),
        .o_frame_done (o_frame_done),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Expected destination beats
    // ------------------------------------------------------------------
    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        logic             done;
    } dest_beat_t;

    dest_beat_t dest_pending[$];
    int         errors = 0;
    int         beats_sent = 0;
    int         send_gap_pct = 22;
    int         recv_stall_pct = 61;

    // ------------------------------------------------------------------
    // Behavioral downscaler: registers, counters and the column line store
    // ------------------------------------------------------------------
    logic [MODE_W-1:0] m_mode = RST_SCALE_MODE;
    int unsigned m_dw = RST_DEST_WIDTH, m_dh = RST_DEST_HEIGHT;
    int unsigned m_cw = RST_CLIP_WIDTH, m_ch = RST_CLIP_HEIGHT;
    int unsigned m_scol, m_srow, m_dcol, m_drow;
    int unsigned m_span_lo, m_span_hi, m_band_lo, m_band_hi;
    int unsigned acc_r[SRC_W], acc_g[SRC_W], acc_b[SRC_W];
    int unsigned acc_lo[SRC_W], acc_hi[SRC_W];

    function automatic int unsigned clamp_u(int unsigned v, int unsigned lo, int unsigned hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic int unsigned cols_used();
        return clamp_u(m_dw, (SRC_W + SPAN - 1) / SPAN, SRC_W);
    endfunction

    function automatic int unsigned rows_used();
        return clamp_u(m_dh, (USED_R + SPAN - 1) / SPAN, USED_R);
    endfunction

    // end of block idx, never empty
    function automatic int unsigned block_end(int unsigned idx, int unsigned total,
                                              int unsigned parts, int unsigned start);
        int unsigned e;
        e = (idx + 1) * total / parts;
        return e <= start ? start + 1 : e;
    endfunction

    function automatic void restart_line();
        m_scol = 0;
        m_dcol = 0;
        m_span_lo = 0;
        m_span_hi = block_end(0, SRC_W, cols_used(), 0);
    endfunction

    function automatic void restart_image();
        restart_line();
        m_srow = 0;
        m_drow = 0;
        m_band_lo = 0;
        m_band_hi = block_end(0, USED_R, rows_used(), 0);
    endfunction

    function automatic int unsigned chan_mean(int unsigned s, int unsigned n, int unsigned top);
        return s / n > top ? top : s / n;
    endfunction

    function automatic int unsigned chan_mid(int unsigned a, int unsigned b);
        return ((((a >> 11) & 31) + ((b >> 11) & 31)) >> 1) << 11 |
               ((((a >> 5) & 63) + ((b >> 5) & 63)) >> 1) << 5 |
               (((a & 31) + (b & 31)) >> 1);
    endfunction

    // Advance the model by one source beat; hit is set when a result leaves.
    function automatic void downscale_beat(input logic [PIX_W-1:0] pix, input logic fs,
                                           output logic hit, output dest_beat_t res);
        int unsigned dw, dh, sc, sr, cw, ch, d, cnt, v;
        hit = 1'b0;
        res = '0;
        if (fs) restart_image();
        dw = cols_used();
        dh = rows_used();
        sc = m_scol;
        sr = m_srow;
        d  = m_dcol;
        if (sr < USED_R && m_drow < dh && d < dw) begin
            if (sr == m_band_lo && sc == m_span_lo) begin
                acc_r[d] = pix[15:11];
                acc_g[d] = pix[10:5];
                acc_b[d] = pix[4:0];
                acc_lo[d] = pix;
                acc_hi[d] = pix;
            end else begin
                acc_r[d] += pix[15:11];
                acc_g[d] += pix[10:5];
                acc_b[d] += pix[4:0];
                if (pix < acc_lo[d]) acc_lo[d] = pix;
                if (pix > acc_hi[d]) acc_hi[d] = pix;
            end
            if (m_mode != MODE_PASS && sc + 1 == m_span_hi && sr + 1 == m_band_hi) begin
                cnt = (m_span_hi - m_span_lo) * (m_band_hi - m_band_lo);
                case (m_mode)
                    MODE_AVG: v = chan_mean(acc_r[d], cnt, 31) << 11 |
                                  chan_mean(acc_g[d], cnt, 63) << 5 |
                                  chan_mean(acc_b[d], cnt, 31);
                    MODE_MID: v = chan_mid(acc_lo[d], acc_hi[d]);
                    default:  v = acc_hi[d];
                endcase
                res = '{pixel: v[15:0], col: d[9:0], row: m_drow[8:0],
                        done: (d + 1 == dw && m_drow + 1 == dh)};
                hit = 1'b1;
            end
        end
        if (m_mode == MODE_PASS) begin
            cw = m_cw < SRC_W ? m_cw : SRC_W;
            ch = m_ch < SRC_R ? m_ch : SRC_R;
            if (sc < cw && sr < ch) begin
                res = '{pixel: pix, col: sc[9:0], row: sr[8:0],
                        done: (sc + 1 == cw && sr + 1 == ch)};
                hit = 1'b1;
            end
        end
        // advance the column span
        if (m_dcol < dw && sc + 1 >= m_span_hi) begin
            m_dcol++;
            if (m_dcol < dw) begin
                m_span_lo = m_span_hi;
                m_span_hi = block_end(m_dcol, SRC_W, dw, m_span_lo);
            end
        end
        m_scol = sc + 1;
        if (m_scol >= SRC_W) begin
            if (sr < USED_R && m_drow < dh && sr + 1 >= m_band_hi) begin
                m_drow++;
                if (m_drow < dh) begin
                    m_band_lo = m_band_hi;
                    m_band_hi = block_end(m_drow, USED_R, dh, m_band_lo);
                end
            end
            restart_line();
            m_srow = sr + 1;
            if (m_srow >= SRC_R) restart_image();
        end
    endfunction

    // ------------------------------------------------------------------
    // Source side: register writes and source beats
    // ------------------------------------------------------------------
    // Write only once the block has drained and settled.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned data);
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (dest_pending.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data[CFG_DATA_W-1:0];
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        case (idx)
            CFG_SCALE_MODE:  m_mode = data[1:0];
            CFG_DEST_WIDTH:  m_dw = data & 10'h3ff;
            CFG_DEST_HEIGHT: m_dh = data & 9'h1ff;
            CFG_CLIP_WIDTH:  m_cw = data & 10'h3ff;
            CFG_CLIP_HEIGHT: m_ch = data & 9'h1ff;
            default: ;
        endcase
    endtask

    // Send one source beat; when fixed is set, the typed result replaces the
    // model's and a clear typed_hit means none is expected.
    task automatic send_pixel(input logic [PIX_W-1:0] pix, input logic fs,
                              input logic fixed, input dest_beat_t typed, input logic typed_hit);
        logic       hit;
        dest_beat_t res;
        @(negedge i_clk);
        while ($urandom_range(99) < send_gap_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_src_pixel   <= pix;
        i_frame_start <= fs;
        do @(posedge i_clk); while (o_in_stall);
        downscale_beat(pix, fs, hit, res);
        if (fixed) begin
            if (typed_hit) dest_pending.push_back(typed);
        end else if (hit) begin
            dest_pending.push_back(res);
        end
        beats_sent++;
        // three idling regimes: sender light, then receiver light, then none
        if (beats_sent == 750) begin
            send_gap_pct = 61;
            recv_stall_pct = 22;
        end else if (beats_sent == 1500) begin
            send_gap_pct = 0;
            recv_stall_pct = 0;
        end
    endtask

    task automatic send_rand(input logic fs);
        send_pixel($urandom_range(16'hffff), fs, 1'b0, '0, 1'b0);
    endtask

    // ------------------------------------------------------------------
    // Directed table
    // ------------------------------------------------------------------
    typedef enum logic [1:0] { ROW_REG, ROW_PIX, ROW_PIX_TYPED, ROW_PIX_NONE } row_kind_t;

    typedef struct packed {
        row_kind_t             kind;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
        logic [PIX_W-1:0]      pix;
        logic                  fs;
        dest_beat_t            res;
    } dir_row_t;

    localparam int DIR_N = 23;
    dir_row_t dir_tab[DIR_N];

    initial begin
        // pass-through, one-pixel clip: first beat closes the frame
        dir_tab[0]  = '{ROW_REG, CFG_SCALE_MODE, 10'(MODE_PASS), 16'h0, 1'b0, '0};
        dir_tab[1]  = '{ROW_REG, CFG_CLIP_WIDTH, 10'd1, 16'h0, 1'b0, '0};
        dir_tab[2]  = '{ROW_REG, CFG_CLIP_HEIGHT, 10'd1, 16'h0, 1'b0, '0};
        dir_tab[3]  = '{ROW_PIX_TYPED, 3'd0, 10'd0, 16'hffff, 1'b1, '{16'hffff, 10'd0, 9'd0, 1'b1}};
        dir_tab[4]  = '{ROW_PIX_NONE, 3'd0, 10'd0, 16'h0000, 1'b0, '0};
        // zero clip emits nothing
        dir_tab[5]  = '{ROW_REG, CFG_CLIP_WIDTH, 10'd0, 16'h0, 1'b0, '0};
        dir_tab[6]  = '{ROW_PIX_NONE, 3'd0, 10'd0, 16'h1234, 1'b1, '0};
        // clip beyond the frame saturates
        dir_tab[7]  = '{ROW_REG, CFG_CLIP_WIDTH, 10'd1023, 16'h0, 1'b0, '0};
        dir_tab[8]  = '{ROW_REG, CFG_CLIP_HEIGHT, 10'd511, 16'h0, 1'b0, '0};
        dir_tab[9]  = '{ROW_PIX_TYPED, 3'd0, 10'd0, 16'ha5a5, 1'b1, '{16'ha5a5, 10'd0, 9'd0, 1'b0}};
        // oversize destination saturates to one source pixel per block
        dir_tab[10] = '{ROW_REG, CFG_SCALE_MODE, 10'(MODE_MAX), 16'h0, 1'b0, '0};
        dir_tab[11] = '{ROW_REG, CFG_DEST_WIDTH, 10'd1023, 16'h0, 1'b0, '0};
        dir_tab[12] = '{ROW_REG, CFG_DEST_HEIGHT, 10'd511, 16'h0, 1'b0, '0};
        dir_tab[13] = '{ROW_PIX_TYPED, 3'd0, 10'd0, 16'hffff, 1'b1, '{16'hffff, 10'd0, 9'd0, 1'b0}};
        dir_tab[14] = '{ROW_PIX_TYPED, 3'd0, 10'd0, 16'h0000, 1'b0, '{16'h0000, 10'd1, 9'd0, 1'b0}};
        dir_tab[15] = '{ROW_REG, CFG_SCALE_MODE, 10'(MODE_AVG), 16'h0, 1'b0, '0};
        dir_tab[16] = '{ROW_PIX_TYPED, 3'd0, 10'd0, 16'h8410, 1'b1, '{16'h8410, 10'd0, 9'd0, 1'b0}};
        // undersize width saturates to four-column spans; midpoint of 0 and max
        dir_tab[17] = '{ROW_REG, CFG_SCALE_MODE, 10'(MODE_MID), 16'h0, 1'b0, '0};
        dir_tab[18] = '{ROW_REG, CFG_DEST_WIDTH, 10'd0, 16'h0, 1'b0, '0};
        dir_tab[19] = '{ROW_PIX, 3'd0, 10'd0, 16'h0000, 1'b1, '0};
        dir_tab[20] = '{ROW_PIX, 3'd0, 10'd0, 16'hffff, 1'b0, '0};
        dir_tab[21] = '{ROW_PIX, 3'd0, 10'd0, 16'h0000, 1'b0, '0};
        dir_tab[22] = '{ROW_PIX, 3'd0, 10'd0, 16'h7bef, 1'b0, '0};
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin
        restart_image();
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_tab[k]) begin
            case (dir_tab[k].kind)
                ROW_REG:       write_reg(dir_tab[k].idx, dir_tab[k].data);
                ROW_PIX:       send_pixel(dir_tab[k].pix, dir_tab[k].fs, 1'b0, '0, 1'b0);
                ROW_PIX_TYPED: send_pixel(dir_tab[k].pix, dir_tab[k].fs, 1'b1, dir_tab[k].res, 1'b1);
                default:       send_pixel(dir_tab[k].pix, dir_tab[k].fs, 1'b1, '0, 1'b0);
            endcase
        end

        // one full row of single-pixel blocks fills every line store entry
        write_reg(CFG_SCALE_MODE, $urandom_range(2));
        write_reg(CFG_DEST_WIDTH, SRC_W);
        write_reg(CFG_DEST_HEIGHT, USED_R);
        for (int c = 0; c < SRC_W; c++) send_rand(c == 0);

        // average: row 0 in four-column spans, then one-column spans over the
        // same band, so sums outgrow the count and saturate
        write_reg(CFG_SCALE_MODE, MODE_AVG);
        write_reg(CFG_DEST_WIDTH, 160);
        write_reg(CFG_DEST_HEIGHT, 200);
        for (int c = 0; c < SRC_W; c++) send_rand(c == 0);
        write_reg(CFG_DEST_WIDTH, SRC_W);
        for (int c = 0; c < SRC_W; c++) send_rand(1'b0);

        // pass-through with a random clip a few rows high
        write_reg(CFG_SCALE_MODE, MODE_PASS);
        write_reg(CFG_CLIP_WIDTH, $urandom_range(SRC_W, 1));
        write_reg(CFG_CLIP_HEIGHT, $urandom_range(3, 1));
        for (int c = 0; c < 120; c++) send_rand(c == 0);

        // mixed settings, mode changes mid-frame and stray frame starts
        for (int p = 0; p < 6; p++) begin
            write_reg(CFG_SCALE_MODE, $urandom_range(3));
            case ($urandom_range(3))
                0:       write_reg(CFG_DEST_WIDTH, $urandom_range(1023));
                1:       write_reg(CFG_DEST_HEIGHT, $urandom_range(511));
                2:       write_reg(CFG_CLIP_WIDTH, $urandom_range(1023));
                default: write_reg(CFG_CLIP_HEIGHT, $urandom_range(511));
            endcase
            for (int c = 0; c < 40; c++) send_rand($urandom_range(99) < 3);
        end

        // drain, then let any trailing beat settle
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (dest_pending.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        if (errors == 0) begin
            $display("PASS frame_box_downscaler");
        end else begin
            $display("FAIL frame_box_downscaler");
        end
        $finish;
    end

    // ------------------------------------------------------------------
    // Receiver stall
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // ------------------------------------------------------------------
    // Scoreboard: compare each destination beat with the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        dest_beat_t want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (dest_pending.size() == 0) begin
                $error("unexpected destination beat pixel %h col %0d row %0d",
                       o_out_pixel, o_out_col, o_out_row);
                errors++;
            end else begin
                want = dest_pending.pop_front();
                if (o_out_pixel !== want.pixel) begin
                    $error("out_pixel expected %h actual %h", want.pixel, o_out_pixel);
                    errors++;
                end
                if (o_out_col !== want.col) begin
                    $error("out_col expected %0d actual %0d", want.col, o_out_col);
                    errors++;
                end
                if (o_out_row !== want.row) begin
                    $error("out_row expected %0d actual %0d", want.row, o_out_row);
                    errors++;
                end
                if (o_frame_done !== want.done) begin
                    $error("frame_done expected %0b actual %0b", want.done, o_frame_done);
                    errors++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: end the run when no beat moves for too long
    // ------------------------------------------------------------------
    int hang_cnt = 0;

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            hang_cnt <= 0;
        end else if (hang_cnt >= HANG_MAX) begin
            $display("FAIL frame_box_downscaler");
            $finish;
        end else begin
            hang_cnt <= hang_cnt + 1;
        end
    end

endmodule
